// ----- rtl/core/integer_to_radix_ascii_assert.svh -----
// ----------------------------------------------------------------------------
// integer_to_radix_ascii assertion macros
// Concurrent check helpers clocked on clk and disabled during rst
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_ASSERT_SVH

// same-cycle implication
`define ITRA_ASSERT_NOW(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("assertion failed: same-cycle check");

// next-cycle implication
`define ITRA_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("assertion failed: next-cycle check");

`endif

// ----- rtl/core/itra_pkg.sv -----
// ----------------------------------------------------------------------------
// itra_pkg
// Shared constants, types and the digit encoder of the radix text converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package itra_pkg;

  localparam int VALUE_W = 64;
  localparam int RADIX_W = 6;
  localparam int CHAR_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_A     = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] DIGIT_TEN  = 8'd10;

  // divider status seen by the controller
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  // digit value to ascii, letters past nine
  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] dw;
    dw = {{(CHAR_W-RADIX_W){1'b0}}, d};
    if (dw > 8'd9) begin
      digit_to_ascii = CHAR_A + dw - DIGIT_TEN;
    end else begin
      digit_to_ascii = CHAR_ZERO + dw;
    end
  endfunction

endpackage

// ----- rtl/core/itra_ram.sv -----
// ----------------------------------------------------------------------------
// itra_ram
// Generic single write port RAM with one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itra_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/core/itra_div.sv -----
// ----------------------------------------------------------------------------
// itra_div
// Bit-serial restoring divider: one quotient bit per cycle, small divisor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module itra_div
  import itra_pkg::*;
#(
  parameter int W = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [W-1:0]       dividend,
  input  logic [RADIX_W-1:0] divisor,
  output logic [W-1:0]       quotient,
  output logic [RADIX_W-1:0] remainder,
  output div_stat_t          stat
);

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic [CNT_W-1:0]   cnt;
  logic [RADIX_W:0]   shifted;
  logic               fits;
  logic [RADIX_W:0]   diff;

  // one trial subtract per cycle
  assign shifted = {remainder, quotient[W-1]};
  assign fits    = shifted >= {1'b0, divisor};
  assign diff    = shifted - {1'b0, divisor};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      stat <= '0;
      cnt  <= '0;
    end else begin
      stat.done <= 1'b0;
      if (start) begin
        stat.busy <= 1'b1;
        cnt       <= CNT_W'(W - 1);
      end else if (stat.busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          stat.busy <= 1'b0;
          stat.done <= 1'b1;
        end
      end
    end
  end

  // quotient and remainder shift
  always_ff @(posedge clk) begin
    if (start) begin
      quotient  <= dividend;
      remainder <= '0;
    end else if (stat.busy) begin
      quotient  <= {quotient[W-2:0], fits};
      remainder <= fits ? diff[RADIX_W-1:0] : shifted[RADIX_W-1:0];
    end
  end

endmodule

// ----- rtl/core/integer_to_radix_ascii.sv -----
// Builds the digits one division at a time with the bit-serial divider,
// then emits the text msd first, stalling while out_ready is low.
// Takes one number at a time: a new value is accepted only when idle.
// Reset (rst, synchronous): idle, output empty, radix back to ten.
// ----------------------------------------------------------------------------
// integer_to_radix_ascii
// Converts a signed integer to ascii text in a runtime radix, msd first
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "integer_to_radix_ascii_assert.svh"

module integer_to_radix_ascii
  import itra_pkg::*;
#(
  parameter int VALUE_BITS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [RADIX_W-1:0] cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [VALUE_W-1:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAR_W-1:0]  char_code,
  output logic               last_char,
  output logic               bad_radix
);

  localparam int ADDR_W = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int CNT_W  = $clog2(VALUE_BITS + 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_SIGN  = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_LOAD  = 3'd5;
  localparam logic [2:0] S_BAD   = 3'd6;

  logic [2:0]            state;
  logic [RADIX_W-1:0]    radix;
  logic [VALUE_BITS-1:0] mag;
  logic                  neg;
  logic [CNT_W-1:0]      count;
  logic [ADDR_W-1:0]     idx;

  logic [VALUE_BITS-1:0] v_in;
  logic                  in_fire;
  logic                  out_free;
  logic                  div_start;
  logic [VALUE_BITS-1:0] div_quo;
  logic [RADIX_W-1:0]    div_rem;
  div_stat_t             div_stat;
  logic                  ram_we;
  logic [CHAR_W-1:0]     ram_wdata;
  logic [CHAR_W-1:0]     ram_rdata;
  logic                  mag_zero;
  logic                  put_sign;

  assign v_in     = value[VALUE_BITS-1:0];
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;
  assign mag_zero = (mag == '0);
  assign put_sign = neg && (radix == RADIX_DEC);

  // radix register
  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_wr_en) begin
      radix <= cfg_wr_data;
    end
  end

  // divider start and digit buffer write
  assign div_start = (state == S_CHECK) && !mag_zero;
  assign ram_we    = ((state == S_CHECK) && mag_zero && (count == '0)) ||
                     ((state == S_DIV) && div_stat.done);
  assign ram_wdata = (state == S_DIV) ? digit_to_ascii(div_rem) : CHAR_ZERO;

  itra_div #(
    .W (VALUE_BITS)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (mag),
    .divisor   (radix),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  itra_ram #(
    .WIDTH (CHAR_W),
    .DEPTH (VALUE_BITS)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (ram_wdata),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  // conversion sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      mag   <= '0;
      neg   <= 1'b0;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            neg   <= v_in[VALUE_BITS-1];
            mag   <= v_in[VALUE_BITS-1] ? (~v_in + 1'b1) : v_in;
            count <= '0;
            state <= (radix < RADIX_MIN) ? S_BAD : S_CHECK;
          end
        end
        S_CHECK: begin
          if (mag_zero) begin
            if (count == '0) begin
              count <= CNT_W'(1);
              idx   <= '0;
            end else begin
              idx <= ADDR_W'(count - CNT_W'(1));
            end
            state <= put_sign ? S_SIGN : S_READ;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            mag   <= div_quo;
            count <= count + 1'b1;
            state <= S_CHECK;
          end
        end
        S_SIGN: begin
          if (out_free) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (out_free) begin
            if (idx == '0) begin
              state <= S_IDLE;
            end else begin
              idx   <= idx - 1'b1;
              state <= S_READ;
            end
          end
        end
        S_BAD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // output beat register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free && (state == S_SIGN || state == S_LOAD || state == S_BAD)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      case (state)
        S_SIGN: begin
          char_code <= CHAR_MINUS;
          last_char <= 1'b0;
          bad_radix <= 1'b0;
        end
        S_LOAD: begin
          char_code <= ram_rdata;
          last_char <= (idx == '0);
          bad_radix <= 1'b0;
        end
        S_BAD: begin
          char_code <= CHAR_NUL;
          last_char <= 1'b1;
          bad_radix <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // checks
  `ITRA_ASSERT_NEXT(a_busy_after_accept, in_fire, !in_ready)
  `ITRA_ASSERT_NOW(a_bad_is_last, out_valid && bad_radix, last_char)
  `ITRA_ASSERT_NOW(a_div_done_in_div, div_stat.done, state == S_DIV)

endmodule

// ----- test/integer_to_radix_ascii_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_tb
// Sends signed 64-bit numbers through the radix text converter under several
// radix settings (decimal, binary, hex, 36, the 6-bit maximum and the two
// error radices) and checks every emitted character, its last flag and its
// error flag against a software conversion kept in a small scoreboard.
// Both handshakes see random gaps, mostly short with a few long ones.
// ----------------------------------------------------------------------------

module integer_to_radix_ascii_tb;
  import itra_pkg::*;

  localparam int CYCLE_LIMIT  = 6_000_000;
  localparam int RANDOM_ITEMS = 117;
  localparam logic [VALUE_W-1:0] VAL_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [VALUE_W-1:0] VAL_MIN = 64'h8000_0000_0000_0000;
  localparam logic [VALUE_W-1:0] VAL_NEG1 = 64'hffff_ffff_ffff_ffff;

  // one output beat as the converter should produce it
  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
    logic              bad;
  } text_beat_t;

  // software conversion plus the queue of characters still owed
  class radix_text_scoreboard;
    logic [RADIX_W-1:0] radix;
    text_beat_t         owed_chars[$];
    int                 errors;
    int                 numbers_noted;
    int                 chars_checked;
    int                 bad_beats;

    function new();
      radix = RADIX_RESET;
      errors = 0;
      numbers_noted = 0;
      chars_checked = 0;
      bad_beats = 0;
    endfunction

    // spell an accepted number in the current radix, msd first
    function void note_value(logic [VALUE_W-1:0] v);
      logic [VALUE_W-1:0] mag;
      logic [VALUE_W-1:0] base;
      logic [VALUE_W-1:0] digit;
      logic [CHAR_W-1:0]  text[$];
      numbers_noted++;
      if (radix < RADIX_MIN) begin
        owed_chars.push_back('{CHAR_NUL, 1'b1, 1'b1});
        return;
      end
      base = {{(VALUE_W-RADIX_W){1'b0}}, radix};
      // most negative value wraps to magnitude 2^63 as unsigned
      mag = v[VALUE_W-1] ? -v : v;
      if (mag == 0) text.push_front(CHAR_ZERO);
      while (mag != 0) begin
        digit = mag % base;
        if (digit > 9) text.push_front(CHAR_A + digit[CHAR_W-1:0] - DIGIT_TEN);
        else text.push_front(CHAR_ZERO + digit[CHAR_W-1:0]);
        mag = mag / base;
      end
      // sign only in decimal
      if (v[VALUE_W-1] && radix == RADIX_DEC) text.push_front(CHAR_MINUS);
      foreach (text[i]) owed_chars.push_back('{text[i], i == text.size() - 1, 1'b0});
    endfunction

    // compare one accepted output beat with the oldest owed character
    function void check_char(logic [CHAR_W-1:0] code, logic last, logic bad);
      text_beat_t want;
      if (owed_chars.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat code=%h last=%b bad=%b", $time, code, last, bad);
        return;
      end
      want = owed_chars.pop_front();
      chars_checked++;
      if (bad === 1'b1) bad_beats++;
      if (code !== want.code) begin
        errors++;
        $display("%0t: char_code expected %h actual %h", $time, want.code, code);
      end
      if (last !== want.last) begin
        errors++;
        $display("%0t: last_char expected %b actual %b", $time, want.last, last);
      end
      if (bad !== want.bad) begin
        errors++;
        $display("%0t: bad_radix expected %b actual %b", $time, want.bad, bad);
      end
    endfunction
  endclass

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_wr_en = 1'b0;
  logic [RADIX_W-1:0] cfg_wr_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [VALUE_W-1:0] value = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [CHAR_W-1:0]  char_code;
  logic               last_char;
  logic               bad_radix;

  radix_text_scoreboard sb = new();
  logic steady = 1'b0;
  int   cycle_count = 0;
  int   radix_settings = 1;

  integer_to_radix_ascii dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .char_code  (char_code),
    .last_char  (last_char),
    .bad_radix  (bad_radix)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("TEST FAILED");
      $finish;
    end
  end

  // gap length: mostly none or short, now and then long
  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 99);
    if (steady) return 0;
    if (sel < 45) return 0;
    if (sel < 85) return $urandom_range(1, 3);
    if (sel < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [RADIX_W-1:0] pick_radix();
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 8) return RADIX_W'($urandom_range(0, 1));
    if (sel < 20) return RADIX_MIN;
    if (sel < 30) return RADIX_DEC;
    if (sel < 45) return RADIX_W'($urandom_range(37, 63));
    return RADIX_W'($urandom_range(3, 36));
  endfunction

  // full-width, small, shortened, corner and near-power-of-radix numbers
  function automatic logic [VALUE_W-1:0] random_value();
    logic [VALUE_W-1:0] v;
    logic [VALUE_W-1:0] base;
    int kind;
    int k;
    base = {{(VALUE_W-RADIX_W){1'b0}}, sb.radix};
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1, 2, 3: v = {$urandom, $urandom};
      4, 5: v = VALUE_W'($urandom_range(0, 2000));
      6: v = {$urandom, $urandom} >> $urandom_range(1, 62);
      7: begin
        case ($urandom_range(0, 5))
          0: v = '0;
          1: v = 1;
          2: v = VAL_MAX;
          3: v = VAL_MIN;
          4: v = VAL_NEG1;
          default: v = VAL_MIN + 1;
        endcase
      end
      default: begin
        v = 1;
        if (base >= 2) begin
          k = $urandom_range(1, 63);
          while (k > 0 && v <= VAL_MAX / base) begin
            v = v * base;
            k--;
          end
        end
        v = v + $urandom_range(0, 2) - 1;
      end
    endcase
    if (kind >= 4 && kind != 7 && $urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  // output side: check each beat, stall at random between beats
  initial begin : char_sink
    int hold;
    hold = 0;
    forever begin
      @(posedge clk);
      if (!rst) begin
        if (out_valid === 1'b1 && out_ready) begin
          sb.check_char(char_code, last_char, bad_radix);
          hold = pick_gap();
        end else if (out_ready && $urandom_range(0, 199) == 0) begin
          hold = pick_gap();
        end
        if (hold > 0) begin
          out_ready <= 1'b0;
          hold--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // one input beat; valid stays up afterwards so a back-to-back beat can follow
  task automatic send_value(input logic [VALUE_W-1:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    value <= v;
    do @(posedge clk); while (in_ready !== 1'b1);
    sb.note_value(v);
  endtask

  // stop sending and hold off until all owed text has come out
  task automatic finish_burst();
    in_valid <= 1'b0;
    while (sb.owed_chars.size() != 0) @(posedge clk);
  endtask

  task automatic write_radix(input logic [RADIX_W-1:0] r);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= r;
    sb.radix = r;
    radix_settings++;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin : stimulus
    int sent;
    int burst;
    sent = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // decimal at the reset radix: zero, signs, digit rollover, both extremes
    send_value(64'd0);
    send_value(64'd1);
    send_value(VAL_NEG1);
    send_value(64'd9);
    send_value(64'd10);
    send_value(VAL_MAX);
    send_value(VAL_MIN);
    send_value(-64'sd1234567890);
    finish_burst();

    // binary: longest texts, no sign for negatives
    write_radix(RADIX_MIN);
    send_value(64'd0);
    send_value(VAL_MIN);
    send_value(VAL_NEG1);
    send_value(VAL_MAX);
    send_value(64'h5555_5555_5555_5555);
    finish_burst();

    // hex: every letter and digit
    write_radix(6'd16);
    send_value(64'hfedc_ba98_7654_3210);
    send_value(64'h0123_4567_89ab_cdef);
    finish_burst();

    // base 36: top letter and its rollover
    write_radix(6'd36);
    send_value(64'd35);
    send_value(64'd36);
    send_value(VAL_MAX);
    finish_burst();

    // base 63: digit codes past the letter z
    write_radix(6'd63);
    send_value(64'd62);
    send_value(VAL_MIN);
    send_value(-64'sd5);
    finish_burst();

    // error radices
    write_radix(6'd0);
    send_value(64'd12345);
    finish_burst();
    write_radix(6'd1);
    send_value(64'd0);
    finish_burst();

    // random bursts, each under a freshly chosen radix
    while (sent < RANDOM_ITEMS) begin
      write_radix(pick_radix());
      steady = ($urandom_range(0, 3) == 0);
      burst = $urandom_range(8, 24);
      if (burst > RANDOM_ITEMS - sent) burst = RANDOM_ITEMS - sent;
      repeat (burst) begin
        send_value(random_value());
        sent++;
        if ($urandom_range(0, 24) == 0) finish_burst();
      end
      finish_burst();
    end
    steady = 1'b0;

    // let any stray beat show up before the verdict
    repeat (100) @(posedge clk);
    $display("converted %0d numbers under %0d radix settings, error radices included",
             sb.numbers_noted, radix_settings);
    $display("checked %0d characters, %0d of them bad-radix beats, %0d errors",
             sb.chars_checked, sb.bad_beats, sb.errors);
    if (sb.errors == 0 && sb.owed_chars.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
